// File: rtl/ring_tone_note_parser_unit_macros.svh
// Assertion macros for the ring-tone note parser checker.
// Both macros expect clk in scope at the point of use; RTNP_ASSERT also needs rst_n.
`ifndef RING_TONE_NOTE_PARSER_UNIT_MACROS_SVH
`define RING_TONE_NOTE_PARSER_UNIT_MACROS_SVH

// Check a property outside reset.
`define RTNP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property that includes the reset cycles.
`define RTNP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/rtnp_pkg.sv
// Shared types, constants and tone tables of the ring-tone note parser.
// No dependencies; used by every module of the block.
package rtnp_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam int PERIOD_W = 15;
  localparam int LENGTH_W = 7;
  localparam int OCT_W    = 3;
  localparam int DLOG_W   = 3;

  localparam logic [PERIOD_W-1:0] PERIOD_START = 15'd18181;
  localparam logic [DLOG_W-1:0]   DLOG_RESET   = 3'd2;
  localparam logic [OCT_W-1:0]    OCT_RESET    = 3'd5;

  // Register indexes on the configuration port
  localparam logic REG_DUR_LOG = 1'b0;
  localparam logic REG_OCTAVE  = 1'b1;

  // Note letter codes; anything not a-g or p is LT_OTHER
  typedef enum logic [3:0] {
    LT_A, LT_B, LT_C, LT_D, LT_E, LT_F, LT_G, LT_P, LT_OTHER
  } letter_t;

  // Classified character word passed from front to back
  typedef struct packed {
    letter_t          letter;
    logic             is_hash;
    logic             is_dot;
    logic             is_comma;
    logic             is_oct;
    logic [OCT_W-1:0] oct;
    logic             is_d1;
    logic             is_d2;
    logic             is_d3;
    logic             is_d4;
    logic             is_d6;
    logic             is_d8;
  } chr_cls_t;

  // Configuration seen by the parser
  typedef struct packed {
    logic [DLOG_W-1:0] dur_log;
    logic [OCT_W-1:0]  octave;
  } cfg_t;

  // Natural tone period of a letter; letters off the table keep the current period
  function automatic logic [PERIOD_W-1:0] natural_period(letter_t lt,
                                                         logic [PERIOD_W-1:0] cur);
    logic [PERIOD_W-1:0] p;
    p = cur;
    unique case (lt)
      LT_A:    p = 15'd18181;
      LT_B:    p = 15'd16197;
      LT_C:    p = 15'd15287;
      LT_D:    p = 15'd13618;
      LT_E:    p = 15'd12131;
      LT_F:    p = 15'd11449;
      LT_G:    p = 15'd10199;
      default: p = cur;
    endcase
    return p;
  endfunction

  // Sharp tone period; letters with no sharp keep the current period
  function automatic logic [PERIOD_W-1:0] sharp_period(letter_t lt,
                                                       logic [PERIOD_W-1:0] cur);
    logic [PERIOD_W-1:0] p;
    p = cur;
    unique case (lt)
      LT_A:    p = 15'd17159;
      LT_C:    p = 15'd14429;
      LT_D:    p = 15'd12852;
      LT_F:    p = 15'd10807;
      LT_G:    p = 15'd9627;
      default: p = cur;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/rtnp_front.sv
// Front stage: accepts text characters and registers their classification.
// Depends on rtnp_pkg for the classified word type.
module rtnp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_text_char,
  output logic               q_valid,
  input  logic               q_ready,
  output rtnp_pkg::chr_cls_t q_data
);

  logic               v_r;
  rtnp_pkg::chr_cls_t cls_r;
  rtnp_pkg::chr_cls_t cls_nxt;

  // Decode one character into letter code and flags
  always_comb begin
    cls_nxt          = '0;
    cls_nxt.is_hash  = (in_text_char == 8'h23);
    cls_nxt.is_dot   = (in_text_char == 8'h2E);
    cls_nxt.is_comma = (in_text_char == 8'h2C);
    cls_nxt.is_oct   = (in_text_char >= 8'h34) && (in_text_char <= 8'h37);
    cls_nxt.oct      = in_text_char[2:0];
    cls_nxt.is_d1    = (in_text_char == 8'h31);
    cls_nxt.is_d2    = (in_text_char == 8'h32);
    cls_nxt.is_d3    = (in_text_char == 8'h33);
    cls_nxt.is_d4    = (in_text_char == 8'h34);
    cls_nxt.is_d6    = (in_text_char == 8'h36);
    cls_nxt.is_d8    = (in_text_char == 8'h38);
    case (in_text_char)
      8'h61:   cls_nxt.letter = rtnp_pkg::LT_A;
      8'h62:   cls_nxt.letter = rtnp_pkg::LT_B;
      8'h63:   cls_nxt.letter = rtnp_pkg::LT_C;
      8'h64:   cls_nxt.letter = rtnp_pkg::LT_D;
      8'h65:   cls_nxt.letter = rtnp_pkg::LT_E;
      8'h66:   cls_nxt.letter = rtnp_pkg::LT_F;
      8'h67:   cls_nxt.letter = rtnp_pkg::LT_G;
      8'h70:   cls_nxt.letter = rtnp_pkg::LT_P;
      default: cls_nxt.letter = rtnp_pkg::LT_OTHER;
    endcase
  end

  // Take a new character whenever the stage is empty or drains this cycle
  assign in_ready = !v_r || q_ready;
  assign q_valid  = v_r;
  assign q_data   = cls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      v_r <= 1'b1;
    end else if (q_ready) begin
      v_r <= 1'b0;
    end
    if (in_valid && in_ready) begin
      cls_r <= cls_nxt;
    end
  end

endmodule

// File: rtl/rtnp_queue.sv
// Short queue of classified character words between front and back.
// Depends on rtnp_pkg for the word type.
module rtnp_queue #(
  parameter int DEPTH = rtnp_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rtnp_pkg::chr_cls_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rtnp_pkg::chr_cls_t out_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rtnp_pkg::chr_cls_t slot_r [DEPTH];
  logic [PW-1:0]      wr_ptr_r;
  logic [PW-1:0]      rd_ptr_r;
  logic [CW-1:0]      count_r;
  logic               push;
  logic               pop;

  assign in_ready  = (count_r != CW'(DEPTH));
  assign out_valid = (count_r != '0);
  assign out_data  = slot_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

// File: rtl/rtnp_back.sv
// Back stage: note parse state machine and result register.
// Depends on rtnp_pkg for word, config types and tone tables.
module rtnp_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rtnp_pkg::cfg_t                 cfg,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  rtnp_pkg::chr_cls_t             q_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rtnp_pkg::PERIOD_W-1:0]  out_tone_period,
  output logic [rtnp_pkg::LENGTH_W-1:0]  out_length_32nds,
  output logic                           out_is_pause,
  output logic                           out_last_note
);

  typedef enum logic [3:0] {
    PH_DUR, PH_DUR3, PH_DUR1, PH_LET, PH_SHARP, PH_DOT1, PH_OCT, PH_DOT2, PH_TERM
  } phase_t;

  phase_t                         phase_r,  phase_nxt;
  logic [rtnp_pkg::LENGTH_W-1:0]  len_r,    len_nxt;
  logic [rtnp_pkg::OCT_W-1:0]     oct_r,    oct_nxt;
  rtnp_pkg::letter_t              letter_r, letter_nxt;
  logic [rtnp_pkg::PERIOD_W-1:0]  period_r, period_nxt;
  logic                           pause_r,  pause_nxt;
  logic                           ov_r,     ov_nxt;
  logic [rtnp_pkg::PERIOD_W-1:0]  o_per_r,  o_per_nxt;
  logic [rtnp_pkg::LENGTH_W-1:0]  o_len_r,  o_len_nxt;
  logic                           o_pau_r,  o_pau_nxt;
  logic                           o_last_r, o_last_nxt;

  logic [rtnp_pkg::LENGTH_W-1:0]  def_len;
  logic                           step;
  logic                           done;
  logic [1:0]                     shift;

  // Take a word whenever the result slot is free or drains this cycle
  assign q_ready = !ov_r || out_ready;
  assign step    = q_valid && q_ready;

  // Default length from the saturated duration log
  assign def_len = (cfg.dur_log > 3'd5) ? 7'd1 : (7'd32 >> cfg.dur_log);

  // One character: walk the phases that it falls through
  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    oct_nxt    = oct_r;
    letter_nxt = letter_r;
    period_nxt = period_r;
    pause_nxt  = pause_r;
    ov_nxt     = ov_r && !out_ready;
    o_per_nxt  = o_per_r;
    o_len_nxt  = o_len_r;
    o_pau_nxt  = o_pau_r;
    o_last_nxt = o_last_r;
    done       = 1'b0;
    shift      = 2'd0;
    if (step) begin
      // duration of a new note
      if (phase_nxt == PH_DUR) begin
        done      = 1'b1;
        oct_nxt   = cfg.octave;
        pause_nxt = 1'b0;
        if (q_data.is_d3) begin
          phase_nxt = PH_DUR3;
        end else if (q_data.is_d1) begin
          phase_nxt = PH_DUR1;
        end else if (q_data.is_d8 || q_data.is_d4 || q_data.is_d2) begin
          len_nxt   = q_data.is_d8 ? 7'd4 : (q_data.is_d4 ? 7'd8 : 7'd16);
          phase_nxt = PH_LET;
        end else begin
          len_nxt    = def_len;
          letter_nxt = q_data.letter;
          phase_nxt  = PH_SHARP;
        end
      end
      // second digit of 32; a lone 3 stands as an unknown letter
      if (!done && phase_nxt == PH_DUR3) begin
        if (q_data.is_d2) begin
          done      = 1'b1;
          len_nxt   = 7'd1;
          phase_nxt = PH_LET;
        end else begin
          len_nxt    = def_len;
          letter_nxt = rtnp_pkg::LT_OTHER;
          phase_nxt  = PH_SHARP;
        end
      end
      // second digit of 16; a lone 1 is a whole note
      if (!done && phase_nxt == PH_DUR1) begin
        done = 1'b1;
        if (q_data.is_d6) begin
          len_nxt   = 7'd2;
          phase_nxt = PH_LET;
        end else begin
          len_nxt    = 7'd32;
          letter_nxt = q_data.letter;
          phase_nxt  = PH_SHARP;
        end
      end
      if (!done && phase_nxt == PH_LET) begin
        done       = 1'b1;
        letter_nxt = q_data.letter;
        phase_nxt  = PH_SHARP;
      end
      // sharp or natural tone of the pending letter
      if (!done && phase_nxt == PH_SHARP) begin
        phase_nxt = PH_DOT1;
        if (q_data.is_hash) begin
          done       = 1'b1;
          period_nxt = rtnp_pkg::sharp_period(letter_nxt, period_nxt);
        end else begin
          period_nxt = rtnp_pkg::natural_period(letter_nxt, period_nxt);
          if (letter_nxt == rtnp_pkg::LT_P) begin
            pause_nxt = 1'b1;
          end
        end
      end
      if (!done && phase_nxt == PH_DOT1) begin
        phase_nxt = PH_OCT;
        if (q_data.is_dot) begin
          done    = 1'b1;
          len_nxt = len_nxt + (len_nxt >> 1);
        end
      end
      if (!done && phase_nxt == PH_OCT) begin
        phase_nxt = PH_DOT2;
        if (q_data.is_oct) begin
          done    = 1'b1;
          oct_nxt = q_data.oct;
        end
      end
      if (!done && phase_nxt == PH_DOT2) begin
        phase_nxt = PH_TERM;
        if (q_data.is_dot) begin
          done    = 1'b1;
          len_nxt = len_nxt + (len_nxt >> 1);
        end
      end
      // terminator: shift by octave, emit, restart
      if (!done) begin
        case (oct_nxt)
          3'd5:    shift = 2'd1;
          3'd6:    shift = 2'd2;
          3'd7:    shift = 2'd3;
          default: shift = 2'd0;
        endcase
        o_per_nxt  = period_nxt >> shift;
        o_len_nxt  = len_nxt;
        o_pau_nxt  = pause_nxt;
        o_last_nxt = !q_data.is_comma;
        ov_nxt     = 1'b1;
        phase_nxt  = PH_DUR;
        period_nxt = q_data.is_comma ? o_per_nxt : rtnp_pkg::PERIOD_START;
      end
    end
  end

  // Hold parse state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_DUR;
      len_r    <= '0;
      oct_r    <= rtnp_pkg::OCT_RESET;
      letter_r <= rtnp_pkg::LT_OTHER;
      period_r <= rtnp_pkg::PERIOD_START;
      pause_r  <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      oct_r    <= oct_nxt;
      letter_r <= letter_nxt;
      period_r <= period_nxt;
      pause_r  <= pause_nxt;
      ov_r     <= ov_nxt;
    end
    o_per_r  <= o_per_nxt;
    o_len_r  <= o_len_nxt;
    o_pau_r  <= o_pau_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_valid        = ov_r;
  assign out_tone_period  = o_per_r;
  assign out_length_32nds = o_len_r;
  assign out_is_pause     = o_pau_r;
  assign out_last_note    = o_last_r;

endmodule

// File: rtl/ring_tone_note_parser_unit.sv
// Top level of the ring-tone note parser: configuration registers and wiring.
// Depends on rtnp_pkg, rtnp_front, rtnp_queue and rtnp_back.
//
//   channel  ports                                    word moves when
//   input    in_valid in_ready in_text_char           in_valid && in_ready
//   result   out_valid out_ready out_tone_period ...  out_valid && out_ready
//   config   psel penable pwrite paddr pwdata prdata  psel && penable && pwrite
//
// One character per cycle sustained while out_ready stays high; the parse step of the
// back state machine settles all fall-through phases combinationally.
// A terminator's result passes through the front register, then a queue slot,
// then the result register before it becomes valid.
// Synchronous active-low reset; no clearing pass, the block is ready at once.
// A stalled result holds its register; the queue absorbs the front meanwhile.
module ring_tone_note_parser_unit #(
  parameter int QUEUE_DEPTH = rtnp_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_text_char,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rtnp_pkg::PERIOD_W-1:0]  out_tone_period,
  output logic [rtnp_pkg::LENGTH_W-1:0]  out_length_32nds,
  output logic                           out_is_pause,
  output logic                           out_last_note,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  rtnp_pkg::cfg_t     cfg_r;
  logic               fq_valid;
  logic               fq_ready;
  rtnp_pkg::chr_cls_t fq_data;
  logic               qb_valid;
  logic               qb_ready;
  rtnp_pkg::chr_cls_t qb_data;

  assign pready = 1'b1;

  // Write configuration registers on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dur_log <= rtnp_pkg::DLOG_RESET;
      cfg_r.octave  <= rtnp_pkg::OCT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        rtnp_pkg::REG_DUR_LOG: cfg_r.dur_log <= pwdata[2:0];
        default:               cfg_r.octave  <= pwdata[2:0];
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (paddr[2])
      rtnp_pkg::REG_DUR_LOG: prdata = {29'd0, cfg_r.dur_log};
      default:               prdata = {29'd0, cfg_r.octave};
    endcase
  end

  rtnp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_text_char (in_text_char),
    .q_valid      (fq_valid),
    .q_ready      (fq_ready),
    .q_data       (fq_data)
  );

  rtnp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  rtnp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (qb_valid),
    .q_ready          (qb_ready),
    .q_data           (qb_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tone_period  (out_tone_period),
    .out_length_32nds (out_length_32nds),
    .out_is_pause     (out_is_pause),
    .out_last_note    (out_last_note)
  );

endmodule

// File: rtl/rtnp_checker.sv
// Port-level checks of the ring-tone note parser, bound to the top level.
// Depends on rtnp_pkg and ring_tone_note_parser_unit_macros.svh.
`include "ring_tone_note_parser_unit_macros.svh"

module rtnp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [rtnp_pkg::PERIOD_W-1:0]  out_tone_period,
  input logic [rtnp_pkg::LENGTH_W-1:0]  out_length_32nds,
  input logic                           out_is_pause,
  input logic                           out_last_note
);

  // Stalled result holds
  `RTNP_ASSERT(a_out_hold,
    (out_valid && !out_ready) |=> (out_valid && $stable(out_tone_period) &&
      $stable(out_length_32nds) && $stable(out_is_pause) && $stable(out_last_note)),
    "result changed while stalled")

  // Reset empties the result slot and opens the input
  `RTNP_ASSERT_RST(a_rst_out, !rst_n |=> !out_valid, "result valid right after reset")
  `RTNP_ASSERT_RST(a_rst_in, !rst_n |=> in_ready, "input not ready right after reset")

  // Result fields stay within their ranges
  `RTNP_ASSERT(a_len_nz, out_valid |-> (out_length_32nds != 7'd0), "zero note length")
  `RTNP_ASSERT(a_per_max, out_valid |-> (out_tone_period <= rtnp_pkg::PERIOD_START),
    "tone period above table maximum")

endmodule

bind ring_tone_note_parser_unit rtnp_checker u_rtnp_checker (.*);
